// ----- design/crd_pkg.sv -----
// shared types, constants and rounding helpers for the camera ray direction core
package crd_pkg;

  localparam int FRAC_BITS = 14;
  localparam logic [12:0] MAX_DIM = 13'd4096;
  localparam logic signed [15:0] FX_ONE = 16'sd16384;

  // pipeline depths of the pixel path
  localparam int FRONT_STAGES = 6;
  localparam int ROOT_STAGES = 31;
  localparam int DIV_STAGES = 17;
  localparam int EYE_LAT = FRONT_STAGES + ROOT_STAGES + DIV_STAGES;
  localparam int ROT_LAT = 3;

  // configuration register indexes
  localparam logic [2:0] CFG_VIEW_DIR_X = 3'd0;
  localparam logic [2:0] CFG_VIEW_DIR_Y = 3'd1;
  localparam logic [2:0] CFG_VIEW_DIR_Z = 3'd2;
  localparam logic [2:0] CFG_VIEWPORT_W = 3'd3;
  localparam logic [2:0] CFG_VIEWPORT_H = 3'd4;
  localparam logic [2:0] CFG_TAN_HALF_FOV = 3'd5;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic signed [15:0] ray_z;
    logic degenerate;
  } ray_t;

  typedef struct packed {
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic signed [15:0] ez;
  } eye_t;

  typedef struct packed {
    logic degen;
    logic signed [15:0] dnx;
    logic signed [15:0] dny;
    logic signed [15:0] dnz;
    logic signed [15:0] rx;
    logic signed [15:0] rz;
    logic signed [16:0] ux;
    logic signed [16:0] uy;
    logic signed [16:0] uz;
  } basis_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  // halve the doubled quotient with rounding, clamp to one, apply sign
  function automatic logic signed [15:0] unit_round(input logic [15:0] q, input logic neg);
    logic [16:0] m;
    logic signed [15:0] r;
    m = ({1'b0, q} + 17'd1) >> 1;
    if (m > 17'd16384) m = 17'd16384;
    r = $signed(m[15:0]);
    return neg ? -r : r;
  endfunction

  // shift right by the fraction width, rounding half away from zero
  function automatic logic signed [21:0] round_shift(input logic signed [35:0] v);
    logic [35:0] mag;
    logic [35:0] m;
    logic signed [21:0] r;
    mag = v[35] ? 36'(-v) : 36'(v);
    m = (mag + (36'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    r = $signed(m[21:0]);
    return v[35] ? -r : r;
  endfunction

  function automatic logic signed [15:0] pack16(input logic signed [21:0] v);
    logic signed [21:0] c;
    c = v;
    if (v > 22'sd16384) c = 22'sd16384;
    if (v < -22'sd16384) c = -22'sd16384;
    return c[15:0];
  endfunction

endpackage

// ----- design/crd_basis.sv -----
// configuration registers and serial camera basis sequencer
module crd_basis (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output crd_pkg::basis_t   basis,
  output logic [12:0]       dim_w,
  output logic [12:0]       dim_h,
  output logic [15:0]       tan_fov,
  output logic              busy
);
  import crd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SUM, S_NORM, S_ROOT, S_DIVLD, S_DIV, S_DIVEND, S_UPMUL, S_UPRND
  } state_t;

  localparam logic [2:0] COMP_DNX = 3'd0;
  localparam logic [2:0] COMP_DNY = 3'd1;
  localparam logic [2:0] COMP_DNZ = 3'd2;
  localparam logic [2:0] COMP_RX  = 3'd3;
  localparam logic [2:0] COMP_RZ  = 3'd4;

  state_t state;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [12:0] vp_w, vp_h;
  logic [15:0] tan;
  logic [31:0] sq_x, sq_y, sq_z, h2;
  logic [61:0] s_acc, rt_n, rt_res, rt_bit;
  logic [4:0]  k;
  logic [30:0] root, rem;
  logic [15:0] quo;
  logic [3:0]  cnt;
  logic [2:0]  comp;
  logic signed [35:0] prod_a, prod_b, prod_c, prod_d;
  logic degen;
  logic signed [15:0] dnx, dny, dnz, rx, rz;
  logic signed [16:0] ux, uy, uz;

  logic [15:0] mag_sel;
  logic        neg_sel;
  logic [46:0] x_wide;
  logic [30:0] x_sel;
  logic [62:0] rt_sum;
  logic        rt_ge;
  logic [31:0] trial;
  logic        div_ge;
  logic [30:0] rem_next;
  logic [31:0] h2_next, l2_next;
  logic signed [15:0] unit_val;

  always_comb begin
    case (comp)
      COMP_DNX: begin mag_sel = abs16(dir_x); neg_sel = dir_x[15]; end
      COMP_DNY: begin mag_sel = abs16(dir_y); neg_sel = dir_y[15]; end
      COMP_DNZ: begin mag_sel = abs16(dir_z); neg_sel = dir_z[15]; end
      COMP_RX:  begin mag_sel = abs16(dir_z); neg_sel = !dir_z[15] && (dir_z != 16'sd0); end
      COMP_RZ:  begin mag_sel = abs16(dir_x); neg_sel = dir_x[15]; end
      default:  begin mag_sel = 16'd0; neg_sel = 1'b0; end
    endcase
  end

  assign x_wide   = {31'd0, mag_sel} << k;
  assign x_sel    = x_wide[30:0];
  assign rt_sum   = {1'b0, rt_res} + {1'b0, rt_bit};
  assign rt_ge    = {1'b0, rt_n} >= rt_sum;
  assign trial    = (cnt == 4'd0) ? {1'b0, rem} : {rem, 1'b0};
  assign div_ge   = trial >= {1'b0, root};
  assign rem_next = div_ge ? 31'(trial - {1'b0, root}) : trial[30:0];
  assign h2_next  = sq_x + sq_z;
  assign l2_next  = h2_next + sq_y;
  assign unit_val = unit_round(quo, neg_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SQ;
      dir_x <= 16'sd0;
      dir_y <= 16'sd0;
      dir_z <= -16'sd16384;
      vp_w  <= 13'd640;
      vp_h  <= 13'd480;
      tan   <= 16'd1697;
      degen <= 1'b0;
      comp  <= COMP_DNX;
      cnt   <= 4'd0;
      k     <= 5'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VIEW_DIR_X:   dir_x <= $signed(cfg_data);
        CFG_VIEW_DIR_Y:   dir_y <= $signed(cfg_data);
        CFG_VIEW_DIR_Z:   dir_z <= $signed(cfg_data);
        CFG_VIEWPORT_W:   vp_w <= cfg_data[12:0];
        CFG_VIEWPORT_H:   vp_h <= cfg_data[12:0];
        CFG_TAN_HALF_FOV: tan <= cfg_data;
        default: ;
      endcase
      state <= S_SQ;
    end else begin
      case (state)
        S_IDLE: ;
        S_SQ: begin
          sq_x  <= 32'(32'(dir_x) * 32'(dir_x));
          sq_y  <= 32'(32'(dir_y) * 32'(dir_y));
          sq_z  <= 32'(32'(dir_z) * 32'(dir_z));
          state <= S_SUM;
        end
        S_SUM: begin
          h2 <= h2_next;
          if (h2_next == 32'd0) begin
            degen <= 1'b1;
            state <= S_IDLE;
          end else begin
            degen <= 1'b0;
            comp  <= COMP_DNX;
            s_acc <= {30'd0, l2_next};
            k     <= 5'd0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (s_acc[61:60] == 2'd0) begin
            s_acc <= s_acc << 2;
            k     <= k + 5'd1;
          end else begin
            rt_n   <= s_acc;
            rt_res <= 62'd0;
            rt_bit <= 62'(1) << 60;
            state  <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (rt_ge) begin
            rt_n   <= 62'(({1'b0, rt_n}) - rt_sum);
            rt_res <= (rt_res >> 1) + rt_bit;
          end else begin
            rt_res <= rt_res >> 1;
          end
          rt_bit <= rt_bit >> 2;
          if (rt_bit == 62'd1) begin
            root  <= rt_ge ? 31'((rt_res >> 1) + rt_bit) : 31'(rt_res >> 1);
            state <= S_DIVLD;
          end
        end
        S_DIVLD: begin
          rem   <= x_sel;
          quo   <= 16'd0;
          cnt   <= 4'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= {quo[14:0], div_ge};
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_DIVEND;
        end
        S_DIVEND: begin
          case (comp)
            COMP_DNX: dnx <= unit_val;
            COMP_DNY: dny <= unit_val;
            COMP_DNZ: dnz <= unit_val;
            COMP_RX:  rx  <= unit_val;
            COMP_RZ:  rz  <= unit_val;
            default: ;
          endcase
          if (comp == COMP_DNZ) begin
            // right vector normalises against the horizontal length
            comp  <= COMP_RX;
            s_acc <= {30'd0, h2};
            k     <= 5'd0;
            state <= S_NORM;
          end else if (comp == COMP_RZ) begin
            state <= S_UPMUL;
          end else begin
            comp  <= comp + 3'd1;
            state <= S_DIVLD;
          end
        end
        S_UPMUL: begin
          prod_a <= 36'(rz) * 36'(dny);
          prod_b <= 36'(rz) * 36'(dnx);
          prod_c <= 36'(rx) * 36'(dnz);
          prod_d <= 36'(rx) * 36'(dny);
          state  <= S_UPRND;
        end
        S_UPRND: begin
          ux    <= 17'(round_shift(-prod_a));
          uy    <= 17'(round_shift(prod_b - prod_c));
          uz    <= 17'(round_shift(prod_d));
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    basis.degen = degen;
    basis.dnx   = dnx;
    basis.dny   = dny;
    basis.dnz   = dnz;
    basis.rx    = rx;
    basis.rz    = rz;
    basis.ux    = ux;
    basis.uy    = uy;
    basis.uz    = uz;
  end

  assign dim_w   = (vp_w == 13'd0) ? 13'd1 : ((vp_w > MAX_DIM) ? MAX_DIM : vp_w);
  assign dim_h   = (vp_h == 13'd0) ? 13'd1 : ((vp_h > MAX_DIM) ? MAX_DIM : vp_h);
  assign tan_fov = tan;
  assign busy    = (state != S_IDLE);

endmodule

// ----- design/crd_div_pipe.sv -----
// pipelined restoring divider giving one rounded unit component
module crd_div_pipe (
  input  logic               clk,
  input  logic               en,
  input  logic [30:0]        x,
  input  logic [30:0]        r,
  input  logic               neg,
  output logic signed [15:0] unit
);
  import crd_pkg::*;

  logic [30:0] rem [16];
  logic [15:0] quo [16];
  logic [30:0] div [16];
  logic        sgn [16];

  genvar j;
  generate
    for (j = 0; j < 16; j++) begin : g_step
      logic [31:0] trial;
      logic [30:0] dvs;
      logic [15:0] q_in;
      logic        s_in;
      logic        ge;
      if (j == 0) begin : g_first
        assign trial = {1'b0, x};
        assign dvs   = r;
        assign q_in  = 16'd0;
        assign s_in  = neg;
      end else begin : g_next
        assign trial = {rem[j-1], 1'b0};
        assign dvs   = div[j-1];
        assign q_in  = quo[j-1];
        assign s_in  = sgn[j-1];
      end
      assign ge = trial >= {1'b0, dvs};
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= ge ? 31'(trial - {1'b0, dvs}) : trial[30:0];
          quo[j] <= {q_in[14:0], ge};
          div[j] <= dvs;
          sgn[j] <= s_in;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) unit <= unit_round(quo[15], sgn[15]);
  end

endmodule

// ----- design/crd_eye.sv -----
// pixel to normalised eye vector: products, squares, normalise, root, divide
module crd_eye (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  crd_pkg::pixel_t pixel,
  input  logic [12:0]     dim_w,
  input  logic [12:0]     dim_h,
  input  logic [15:0]     tan_fov,
  output logic            out_valid,
  output crd_pkg::eye_t   eye
);
  import crd_pkg::*;

  typedef struct packed {
    logic [30:0] xa;
    logic [30:0] xb;
    logic [30:0] xc;
    logic        sa;
    logic        sb;
  } carry_t;

  logic [EYE_LAT-1:0] vp;

  // stage 1
  logic signed [14:0] dxw, dyh;
  logic signed [16:0] tsg;
  logic signed [31:0] s1_a, s1_b;
  logic [24:0] s1_cmag;
  // stage 2
  logic [31:0] abs_a, abs_b;
  logic [28:0] s2_amag, s2_bmag;
  logic [57:0] s2_asq, s2_bsq;
  logic [49:0] s2_csq;
  logic [24:0] s2_cmag;
  logic s2_sa, s2_sb;
  // stage 3
  logic [59:0] s3_s;
  logic [28:0] s3_amag, s3_bmag;
  logic [24:0] s3_cmag;
  logic s3_sa, s3_sb;
  // stage 4
  logic [63:0] s_pad;
  logic [3:0]  nz_c;
  logic [3:0]  pos_c [4];
  logic [3:0]  s4_nz;
  logic [3:0]  s4_pos [4];
  logic [59:0] s4_s;
  logic [28:0] s4_amag, s4_bmag;
  logic [24:0] s4_cmag;
  logic s4_sa, s4_sb;
  // stage 5
  logic [5:0]  msb;
  logic [5:0]  k_w;
  logic [4:0]  s5_k;
  logic [59:0] s5_s;
  logic [28:0] s5_amag, s5_bmag;
  logic [24:0] s5_cmag;
  logic s5_sa, s5_sb;
  // stage 6 onward
  logic [46:0] sh_a, sh_b, sh_c;
  logic [61:0] rt_n [32];
  logic [61:0] rt_res [32];
  carry_t      cr [32];

  always_ff @(posedge clk) begin
    if (rst) vp <= '0;
    else if (en) vp <= {vp[EYE_LAT-2:0], in_valid};
  end
  assign out_valid = vp[EYE_LAT-1];

  assign dxw = $signed({2'b0, pixel.pixel_x, 1'b0}) - $signed({2'b0, dim_w});
  assign dyh = $signed({2'b0, pixel.pixel_y, 1'b0}) - $signed({2'b0, dim_h});
  assign tsg = $signed({1'b0, tan_fov});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a    <= 32'(dxw) * 32'(tsg);
      s1_b    <= 32'(dyh) * 32'(tsg);
      s1_cmag <= {dim_h, 12'd0};
    end
  end

  assign abs_a = s1_a[31] ? 32'(-s1_a) : 32'(s1_a);
  assign abs_b = s1_b[31] ? 32'(-s1_b) : 32'(s1_b);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_amag <= abs_a[28:0];
      s2_bmag <= abs_b[28:0];
      s2_asq  <= abs_a[28:0] * abs_a[28:0];
      s2_bsq  <= abs_b[28:0] * abs_b[28:0];
      s2_csq  <= s1_cmag * s1_cmag;
      s2_cmag <= s1_cmag;
      s2_sa   <= s1_a[31];
      s2_sb   <= s1_b[31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_s    <= {2'd0, s2_asq} + {2'd0, s2_bsq} + {10'd0, s2_csq};
      s3_amag <= s2_amag;
      s3_bmag <= s2_bmag;
      s3_cmag <= s2_cmag;
      s3_sa   <= s2_sa;
      s3_sb   <= s2_sb;
    end
  end

  // leading one search, first per 16-bit chunk
  assign s_pad = {4'd0, s3_s};
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      nz_c[c]  = |s_pad[16*c +: 16];
      pos_c[c] = 4'd0;
      for (int b = 0; b < 16; b++) begin
        if (s_pad[16*c + b]) pos_c[c] = 4'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nz   <= nz_c;
      s4_pos  <= pos_c;
      s4_s    <= s3_s;
      s4_amag <= s3_amag;
      s4_bmag <= s3_bmag;
      s4_cmag <= s3_cmag;
      s4_sa   <= s3_sa;
      s4_sb   <= s3_sb;
    end
  end

  always_comb begin
    msb = 6'd0;
    for (int c = 0; c < 4; c++) begin
      if (s4_nz[c]) msb = {2'(c), s4_pos[c]};
    end
  end
  // shift by pairs until the sum reaches the top two bits of 62
  assign k_w = 6'd61 - msb;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_k    <= k_w[5:1];
      s5_s    <= s4_s;
      s5_amag <= s4_amag;
      s5_bmag <= s4_bmag;
      s5_cmag <= s4_cmag;
      s5_sa   <= s4_sa;
      s5_sb   <= s4_sb;
    end
  end

  assign sh_a = {18'd0, s5_amag} << s5_k;
  assign sh_b = {18'd0, s5_bmag} << s5_k;
  assign sh_c = {22'd0, s5_cmag} << s5_k;

  always_ff @(posedge clk) begin
    if (en) begin
      rt_n[0]   <= {2'd0, s5_s} << {s5_k, 1'b0};
      rt_res[0] <= 62'd0;
      cr[0].xa  <= sh_a[30:0];
      cr[0].xb  <= sh_b[30:0];
      cr[0].xc  <= sh_c[30:0];
      cr[0].sa  <= s5_sa;
      cr[0].sb  <= s5_sb;
    end
  end

  genvar i;
  generate
    for (i = 0; i < ROOT_STAGES; i++) begin : g_root
      localparam logic [61:0] BITV = 62'(1) << (60 - 2 * i);
      logic [62:0] sum;
      logic        ge;
      assign sum = {1'b0, rt_res[i]} + {1'b0, BITV};
      assign ge  = {1'b0, rt_n[i]} >= sum;
      always_ff @(posedge clk) begin
        if (en) begin
          rt_n[i+1]   <= ge ? 62'({1'b0, rt_n[i]} - sum) : rt_n[i];
          rt_res[i+1] <= ge ? (rt_res[i] >> 1) + BITV : rt_res[i] >> 1;
          cr[i+1]     <= cr[i];
        end
      end
    end
  endgenerate

  crd_div_pipe u_div_x (
    .clk  (clk),
    .en   (en),
    .x    (cr[ROOT_STAGES].xa),
    .r    (rt_res[ROOT_STAGES][30:0]),
    .neg  (cr[ROOT_STAGES].sa),
    .unit (eye.ex)
  );

  crd_div_pipe u_div_y (
    .clk  (clk),
    .en   (en),
    .x    (cr[ROOT_STAGES].xb),
    .r    (rt_res[ROOT_STAGES][30:0]),
    .neg  (cr[ROOT_STAGES].sb),
    .unit (eye.ey)
  );

  // the depth term is always negative
  crd_div_pipe u_div_z (
    .clk  (clk),
    .en   (en),
    .x    (cr[ROOT_STAGES].xc),
    .r    (rt_res[ROOT_STAGES][30:0]),
    .neg  (1'b1),
    .unit (eye.ez)
  );

endmodule

// ----- design/crd_rotate.sv -----
// rotation of the eye vector into world space by the camera basis
module crd_rotate (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  crd_pkg::eye_t   eye,
  input  crd_pkg::basis_t basis,
  output logic            out_valid,
  output crd_pkg::ray_t   ray
);
  import crd_pkg::*;

  logic [ROT_LAT-1:0] vp;
  logic signed [35:0] p_rxex, p_uxey, p_dxez, p_uyey, p_dyez, p_rzex, p_uzey, p_dzez;
  logic signed [35:0] sum_x, sum_y, sum_z;

  always_ff @(posedge clk) begin
    if (rst) vp <= '0;
    else if (en) vp <= {vp[ROT_LAT-2:0], in_valid};
  end
  assign out_valid = vp[ROT_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      p_rxex <= 36'(basis.rx) * 36'(eye.ex);
      p_uxey <= 36'(basis.ux) * 36'(eye.ey);
      p_dxez <= 36'(basis.dnx) * 36'(eye.ez);
      p_uyey <= 36'(basis.uy) * 36'(eye.ey);
      p_dyez <= 36'(basis.dny) * 36'(eye.ez);
      p_rzex <= 36'(basis.rz) * 36'(eye.ex);
      p_uzey <= 36'(basis.uz) * 36'(eye.ey);
      p_dzez <= 36'(basis.dnz) * 36'(eye.ez);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_x <= p_rxex + p_uxey - p_dxez;
      sum_y <= p_uyey - p_dyez;
      sum_z <= p_rzex + p_uzey - p_dzez;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (basis.degen) begin
        ray.ray_x      <= 16'sd0;
        ray.ray_y      <= 16'sd0;
        ray.ray_z      <= 16'sd0;
        ray.degenerate <= 1'b1;
      end else begin
        ray.ray_x      <= pack16(round_shift(sum_x));
        ray.ray_y      <= pack16(round_shift(sum_y));
        ray.ray_z      <= pack16(round_shift(sum_z));
        ray.degenerate <= 1'b0;
      end
    end
  end

endmodule

// ----- design/camera_ray_direction_core.sv -----
// pinhole camera primary ray direction core, top level
// throughput: one pixel per cycle while pixel_stall is low, set by the 31-stage root
// and 17-stage divide pipes
// after reset and after every configuration write the serial basis unit recomputes
// the camera frame with pixel_stall held high
// reset (rst, synchronous) empties the pipe and restores the default camera
module camera_ray_direction_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  output logic            pixel_stall,
  input  crd_pkg::pixel_t pixel,
  output logic            ray_valid,
  input  logic            ray_stall,
  output crd_pkg::ray_t   ray,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import crd_pkg::*;

  basis_t basis;
  logic [12:0] dim_w, dim_h;
  logic [15:0] tan_fov;
  logic busy, en;
  logic eye_valid, rot_valid, skid_valid;
  eye_t eye;
  ray_t rot_ray, skid_ray;

  assign cfg_ready   = 1'b1;
  // pipe moves whenever the skid word is free
  assign en          = !skid_valid;
  assign pixel_stall = !en || busy;

  crd_basis u_basis (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .basis     (basis),
    .dim_w     (dim_w),
    .dim_h     (dim_h),
    .tan_fov   (tan_fov),
    .busy      (busy)
  );

  crd_eye u_eye (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel_valid && !pixel_stall),
    .pixel     (pixel),
    .dim_w     (dim_w),
    .dim_h     (dim_h),
    .tan_fov   (tan_fov),
    .out_valid (eye_valid),
    .eye       (eye)
  );

  crd_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (eye_valid),
    .eye       (eye),
    .basis     (basis),
    .out_valid (rot_valid),
    .ray       (rot_ray)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!ray_stall) begin
        ray        <= skid_ray;
        skid_valid <= 1'b0;
      end
    end else if (rot_valid) begin
      if (!ray_valid || !ray_stall) begin
        ray       <= rot_ray;
        ray_valid <= 1'b1;
      end else begin
        skid_ray   <= rot_ray;
        skid_valid <= 1'b1;
      end
    end else if (!ray_stall) begin
      ray_valid <= 1'b0;
    end
  end

endmodule
